/* src/rbp_pkg.sv */
// Shared types and constants for the reference-counted buffer pool.
// No dependencies; imported by the controller, datapath and top level.
package rbp_pkg;

  localparam int unsigned POOL_SIZE = 128;
  localparam int unsigned IDX_W     = $clog2(POOL_SIZE);
  localparam int unsigned DEPTH_W   = IDX_W + 1;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned STATUS_W  = 3;

  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(POOL_SIZE);

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RETAIN  = 2'd1,
    MODE_RELEASE = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_IGNORED   = 3'd2,
    STAT_SATURATED = 3'd3,
    STAT_UNREF     = 3'd4
  } status_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic take;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_stat_t;

endpackage

/* src/refcounted_buffer_pool_top.sv */
// Reference-counted buffer pool: LIFO free stack plus per-buffer counts.
// Each request is captured, its memory words read into registers, then
// executed with write-back; execute waits while the result is stalled.
// Beats are taken only after execute, even while a result waits.
// Reset: pool full with index 127 on top, all counts zero, no warm-up pass.
module refcounted_buffer_pool_top
  import rbp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [IDX_W-1:0]    handle_i,
  input  logic                handle_null_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [IDX_W-1:0]    granted_index_o,
  output logic                returned_to_pool_o,
  output logic [CNT_W-1:0]    new_count_o,
  output logic [DEPTH_W-1:0]  free_available_o
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  rbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rbp_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .mode_i             (mode_i),
    .handle_i           (handle_i),
    .handle_null_i      (handle_null_i),
    .out_valid_o        (out_valid_o),
    .status_o           (status_o),
    .granted_index_o    (granted_index_o),
    .returned_to_pool_o (returned_to_pool_o),
    .new_count_o        (new_count_o),
    .free_available_o   (free_available_o)
  );

endmodule

/* src/rbp_ctrl.sv */
// Request sequencer for the buffer pool: capture, memory read, execute.
// Depends on rbp_pkg; drives commands into rbp_datapath.
module rbp_ctrl
  import rbp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     out_stall_i,
  input  dp_stat_t stat_i,
  output ctl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    cmd_o.take = stat_i.out_full & ~out_stall_i;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (!stat_i.out_full || !out_stall_i) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/rbp_datapath.sv */
// Free stack, reference count memory, request registers and result register.
// Depends on rbp_pkg; sequenced by rbp_ctrl.
module rbp_datapath
  import rbp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctl_cmd_t            cmd_i,
  output dp_stat_t            stat_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [IDX_W-1:0]    handle_i,
  input  logic                handle_null_i,
  output logic                out_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [IDX_W-1:0]    granted_index_o,
  output logic                returned_to_pool_o,
  output logic [CNT_W-1:0]    new_count_o,
  output logic [DEPTH_W-1:0]  free_available_o
);

  logic [IDX_W-1:0] stack_mem [POOL_SIZE];
  logic [CNT_W-1:0] cnt_mem   [POOL_SIZE];
  logic [POOL_SIZE-1:0] stack_vld_q, cnt_vld_q;

  logic [MODE_W-1:0]  mode_q;
  logic [IDX_W-1:0]   handle_q;
  logic               null_q;
  logic [IDX_W-1:0]   stk_addr_q;
  logic [IDX_W-1:0]   stk_rd_q;
  logic               stk_vld_rd_q;
  logic [CNT_W-1:0]   cnt_rd_q;
  logic               cnt_vld_rd_q;
  logic [DEPTH_W-1:0] depth_q, depth_d;

  logic                out_valid_q;
  status_e             status_q, status_d;
  logic [IDX_W-1:0]    granted_q, granted_d;
  logic                returned_q, returned_d;
  logic [CNT_W-1:0]    count_q, count_d;

  logic [IDX_W-1:0] top_idx;
  logic [CNT_W-1:0] cur_cnt;
  logic             cnt_we, stk_we;
  logic [IDX_W-1:0] cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata;

  assign top_idx = stk_vld_rd_q ? stk_rd_q : stk_addr_q;
  assign cur_cnt = cnt_vld_rd_q ? cnt_rd_q : '0;

  always_comb begin
    depth_d    = depth_q;
    status_d   = STAT_OK;
    granted_d  = '0;
    returned_d = 1'b0;
    count_d    = '0;
    cnt_we     = 1'b0;
    stk_we     = 1'b0;
    cnt_waddr  = handle_q;
    cnt_wdata  = '0;
    case (mode_q)
      MODE_ALLOC: begin
        if (depth_q == '0) begin
          status_d = STAT_EMPTY;
        end else begin
          depth_d   = depth_q - DEPTH_W'(1);
          granted_d = top_idx;
          count_d   = CNT_W'(1);
          cnt_we    = 1'b1;
          cnt_waddr = top_idx;
          cnt_wdata = CNT_W'(1);
        end
      end
      MODE_RETAIN: begin
        if (null_q) begin
          status_d = STAT_IGNORED;
        end else if (cur_cnt == CNT_MAX) begin
          status_d = STAT_SATURATED;
          count_d  = CNT_MAX;
        end else begin
          count_d   = cur_cnt + CNT_W'(1);
          cnt_we    = 1'b1;
          cnt_wdata = cur_cnt + CNT_W'(1);
        end
      end
      MODE_RELEASE: begin
        if (null_q) begin
          status_d = STAT_IGNORED;
        end else if (cur_cnt == '0) begin
          status_d = STAT_UNREF;
        end else begin
          count_d   = cur_cnt - CNT_W'(1);
          cnt_we    = 1'b1;
          cnt_wdata = cur_cnt - CNT_W'(1);
          if (cur_cnt == CNT_W'(1) && depth_q < DEPTH_MAX) begin
            stk_we     = 1'b1;
            depth_d    = depth_q + DEPTH_W'(1);
            returned_d = 1'b1;
          end
        end
      end
      default: begin
        status_d = STAT_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      stk_rd_q <= stack_mem[stk_addr_q];
      cnt_rd_q <= cnt_mem[handle_i];
    end
    if (cmd_i.exec && stk_we) begin
      stack_mem[depth_q[IDX_W-1:0]] <= handle_q;
    end
    if (cmd_i.exec && cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q       <= mode_i;
      handle_q     <= handle_i;
      null_q       <= handle_null_i;
      stk_vld_rd_q <= stack_vld_q[stk_addr_q];
      cnt_vld_rd_q <= cnt_vld_q[handle_i];
    end
    if (cmd_i.exec) begin
      status_q   <= status_d;
      granted_q  <= granted_d;
      returned_q <= returned_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_vld_q <= '0;
      cnt_vld_q   <= '0;
      depth_q     <= DEPTH_MAX;
      stk_addr_q  <= IDX_W'(POOL_SIZE - 1);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        depth_q    <= depth_d;
        stk_addr_q <= depth_d[IDX_W-1:0] - IDX_W'(1);
        if (stk_we) begin
          stack_vld_q[depth_q[IDX_W-1:0]] <= 1'b1;
        end
        if (cnt_we) begin
          cnt_vld_q[cnt_waddr] <= 1'b1;
        end
        out_valid_q <= 1'b1;
      end else if (cmd_i.take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.out_full    = out_valid_q;
  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign granted_index_o    = granted_q;
  assign returned_to_pool_o = returned_q;
  assign new_count_o        = count_q;
  assign free_available_o   = depth_q;

endmodule

/* bench/tb_refcounted_buffer_pool_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for refcounted_buffer_pool_top: directed corner requests, then random
// fill/drain traffic with exhaust and saturate bursts under sender and receiver stalls.
// Depends on rbp_pkg and the top level; a small ledger class tracks the pool and checks beats.
module tb_refcounted_buffer_pool_top;
  import rbp_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;

  typedef struct {
    status_e              status;
    logic [IDX_W-1:0]     granted;
    logic                 returned;
    logic [CNT_W-1:0]     count;
    logic [DEPTH_W-1:0]   free_avail;
  } reply_t;

  class pool_ledger;
    logic [IDX_W-1:0] free_stack [POOL_SIZE];
    logic [CNT_W-1:0] ref_count [POOL_SIZE];
    int unsigned      free_depth;
    reply_t           pending_replies [$];
    int unsigned      mismatches;

    function new();
      for (int i = 0; i < POOL_SIZE; i++) begin
        free_stack[i] = IDX_W'(i);
        ref_count[i]  = '0;
      end
      free_depth = POOL_SIZE;
      mismatches = 0;
    endfunction

    function logic [IDX_W-1:0] pick_live();
      int unsigned live [$];
      foreach (ref_count[i]) if (ref_count[i] != 0) live.push_back(i);
      if (live.size() == 0) return IDX_W'($urandom_range(POOL_SIZE - 1, 0));
      return IDX_W'(live[$urandom_range(live.size() - 1, 0)]);
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] handle,
                               logic is_null);
      reply_t           r;
      logic [IDX_W-1:0] idx;
      r = '{status: STAT_OK, granted: '0, returned: 1'b0, count: '0, free_avail: '0};
      case (mode)
        MODE_ALLOC: begin
          if (free_depth == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            free_depth--;
            idx = free_stack[free_depth];
            ref_count[idx] = CNT_W'(1);
            r.granted = idx;
            r.count = CNT_W'(1);
          end
        end
        MODE_RETAIN: begin
          if (is_null) begin
            r.status = STAT_IGNORED;
          end else begin
            if (ref_count[handle] == CNT_MAX) r.status = STAT_SATURATED;
            else ref_count[handle]++;
            r.count = ref_count[handle];
          end
        end
        MODE_RELEASE: begin
          if (is_null) begin
            r.status = STAT_IGNORED;
          end else if (ref_count[handle] == 0) begin
            r.status = STAT_UNREF;
          end else begin
            ref_count[handle]--;
            r.count = ref_count[handle];
            if (r.count == 0 && free_depth < POOL_SIZE) begin
              free_stack[free_depth] = handle;
              free_depth++;
              r.returned = 1'b1;
            end
          end
        end
        default: r.status = STAT_IGNORED;
      endcase
      r.free_avail = DEPTH_W'(free_depth);
      pending_replies.push_back(r);
    endfunction

    function void compare(string field, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t %s mismatch: expected %0d actual %0d", $time, field, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_reply(logic [STATUS_W-1:0] status, logic [IDX_W-1:0] granted,
                              logic returned, logic [CNT_W-1:0] count,
                              logic [DEPTH_W-1:0] free_avail);
      reply_t e;
      if (pending_replies.size() == 0) begin
        $display("%0t unexpected beat: expected none actual status %0d", $time, status);
        mismatches++;
        return;
      end
      e = pending_replies.pop_front();
      compare("status", e.status, status);
      compare("granted_index", e.granted, granted);
      compare("returned_to_pool", e.returned, returned);
      compare("new_count", e.count, count);
      compare("free_available", e.free_avail, free_avail);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [MODE_W-1:0]   mode_i = '0;
  logic [IDX_W-1:0]    handle_i = '0;
  logic                handle_null_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [IDX_W-1:0]    granted_index_o;
  logic                returned_to_pool_o;
  logic [CNT_W-1:0]    new_count_o;
  logic [DEPTH_W-1:0]  free_available_o;

  pool_ledger  ledger;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  refcounted_buffer_pool_top u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .handle_i           (handle_i),
    .handle_null_i      (handle_null_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .granted_index_o    (granted_index_o),
    .returned_to_pool_o (returned_to_pool_o),
    .new_count_o        (new_count_o),
    .free_available_o   (free_available_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("FAIL refcounted_buffer_pool_top");
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99, 0) < rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      ledger.check_reply(status_o, granted_index_o, returned_to_pool_o, new_count_o,
                         free_available_o);
    end
  end

  task automatic send_req(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] handle, logic is_null);
    @(negedge clk_i);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    handle_i      <= handle;
    handle_null_i <= is_null;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ledger.note_request(mode, handle, is_null);
  endtask

  task automatic send_random(bit filling);
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < (filling ? 45 : 15))
      send_req(MODE_ALLOC, IDX_W'($urandom), 1'($urandom));
    else if (roll < (filling ? 65 : 35))
      send_req(MODE_RETAIN, ledger.pick_live(), 1'b0);
    else if (roll < 88)
      send_req(MODE_RELEASE, ledger.pick_live(), 1'b0);
    else
      send_req(MODE_W'($urandom), IDX_W'($urandom), 1'($urandom));
  endtask

  initial begin
    logic [IDX_W-1:0] hot;
    ledger = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // release at zero, then a retain/release of a free buffer while the stack is full
    send_req(MODE_RELEASE, 7'd0, 1'b0);
    send_req(MODE_RETAIN, 7'd5, 1'b0);
    send_req(MODE_RELEASE, 7'd5, 1'b0);
    send_req(MODE_ALLOC, 7'h7F, 1'b1);
    send_req(MODE_ALLOC, 7'd0, 1'b0);
    send_req(MODE_RETAIN, 7'd127, 1'b0);
    send_req(MODE_RELEASE, 7'd127, 1'b0);
    send_req(MODE_RELEASE, 7'd127, 1'b0);
    send_req(MODE_RELEASE, 7'd127, 1'b0);
    send_req(MODE_RETAIN, 7'h7F, 1'b1);
    send_req(MODE_RELEASE, 7'd0, 1'b1);
    send_req(MODE_UNDEF, 7'h7F, 1'b1);
    send_req(MODE_UNDEF, 7'd0, 1'b0);
    send_req(MODE_ALLOC, 7'd0, 1'b0);
    send_req(MODE_RETAIN, 7'd126, 1'b0);
    send_req(MODE_RELEASE, 7'd126, 1'b0);
    send_req(MODE_RELEASE, 7'd126, 1'b0);
    send_req(MODE_RETAIN, 7'd0, 1'b0);
    send_req(MODE_RELEASE, 7'd0, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 45 : 0;
      rx_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 16 : 0;
      if (phase == 0) begin
        while (ledger.free_depth != 0) send_req(MODE_ALLOC, IDX_W'($urandom), 1'b0);
        repeat (3) send_req(MODE_ALLOC, IDX_W'($urandom), 1'($urandom));
      end
      if (phase == 1) begin
        hot = ledger.pick_live();
        repeat (256) send_req(MODE_RETAIN, hot, 1'b0);
        repeat (4) send_req(MODE_RELEASE, hot, 1'b0);
      end
      repeat (9) begin
        automatic bit filling = 1'($urandom);
        repeat (50) send_random(filling);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (ledger.pending_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (ledger.mismatches == 0) begin
      $display("PASS refcounted_buffer_pool_top");
    end else begin
      $display("FAIL refcounted_buffer_pool_top");
    end
    $finish;
  end

endmodule
